/* sv/tlvp_pkg.sv */
package tlvp_pkg;

	localparam int NUM_CFG = 6;
	localparam logic [2:0] CFG_NAME    = 3'd0;
	localparam logic [2:0] CFG_PAYLOAD = 3'd1;
	localparam logic [2:0] CFG_END     = 3'd2;
	localparam logic [2:0] CFG_SEGMENT = 3'd3;
	localparam logic [2:0] CFG_CHUNK   = 3'd4;
	localparam logic [2:0] CFG_META    = 3'd5;

	localparam logic [1:0] EV_COMPONENT = 2'd0;
	localparam logic [1:0] EV_ACCEPT    = 2'd1;
	localparam logic [1:0] EV_REJECT    = 2'd2;

	localparam logic [2:0] PH_LEAD      = 3'd0;
	localparam logic [2:0] PH_TOP_HDR   = 3'd1;
	localparam logic [2:0] PH_TOP_SKIP  = 3'd2;
	localparam logic [2:0] PH_END_VAL   = 3'd3;
	localparam logic [2:0] PH_NAME_HDR  = 3'd4;
	localparam logic [2:0] PH_COMP_VAL  = 3'd5;
	localparam logic [2:0] PH_META_HDR  = 3'd6;
	localparam logic [2:0] PH_DRAIN     = 3'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic        last_of_run;
		logic [15:0] message_type;
		logic [6:0]  component_index;
		logic [15:0] item_offset;
		logic [15:0] item_length;
		logic [31:0] chunk_number;
		logic        has_chunk;
		logic [32:0] final_block;
		logic [6:0]  component_count;
		logic [15:0] name_offset;
		logic [15:0] name_length;
	} out_item_t;

	typedef struct packed {
		logic [15:0] name_code;
		logic [15:0] payload_code;
		logic [15:0] end_code;
		logic [15:0] segment_code;
		logic [15:0] chunk_code;
		logic [15:0] meta_code;
	} cfg_t;

endpackage

/* sv/tlvp_if.sv */
interface tlvp_in_if;
	import tlvp_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface tlvp_out_if;
	import tlvp_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface tlvp_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

/* sv/tlv_packet_name_parser_core.sv */
// results of an accepted byte are registered in the result queue before they reach the output
// throughput: one byte per cycle while the output keeps up; a byte may cause two results
// the input stalls only when the four-entry result queue could not take two more
// reset: arst_n clears parse state and the queue and restores the type codes
module tlv_packet_name_parser_core
	import tlvp_pkg::*;
#(
	parameter int MAX_COMPONENTS = 64
) (
	input logic         clk,
	input logic         arst_n,
	tlvp_in_if.sink     in_ch,
	tlvp_out_if.source  out_ch,
	tlvp_cfg_if.sink    cfg
);
	cfg_t      codes;
	logic      step, v0, v1, can_take;
	out_item_t e0, e1;

	assign in_ch.ready = can_take;
	assign step = in_ch.valid && can_take;

	tlvp_regs u_regs (.clk(clk), .arst_n(arst_n), .cfg(cfg), .codes(codes));

	tlvp_parser #(.MAX_COMPONENTS(MAX_COMPONENTS)) u_parser (
		.clk(clk), .arst_n(arst_n), .codes(codes), .step(step),
		.item(in_ch.payload), .ev0_valid(v0), .ev0(e0), .ev1_valid(v1), .ev1(e1)
	);

	tlvp_outq u_q (
		.clk(clk), .arst_n(arst_n), .wr0(step && v0), .d0(e0),
		.wr1(step && v1), .d1(e1), .can_take(can_take), .out(out_ch)
	);

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |-> u_q.cnt_q <= 3'd2)
		else $error("byte taken without queue room");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		u_q.cnt_q <= 3'd4)
		else $error("queue count overflow");
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(step && in_ch.payload.last_byte) |=> u_parser.pos_q == 16'd0)
		else $error("position not cleared after last byte");
endmodule

/* sv/tlvp_regs.sv */
module tlvp_regs
	import tlvp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	tlvp_cfg_if.sink    cfg,
	output cfg_t        codes
);
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes.name_code    <= 16'd0;
			codes.payload_code <= 16'd1;
			codes.end_code     <= 16'd25;
			codes.segment_code <= 16'd1;
			codes.chunk_code   <= 16'd16;
			codes.meta_code    <= 16'd17;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_NAME:    codes.name_code    <= cfg.data;
				CFG_PAYLOAD: codes.payload_code <= cfg.data;
				CFG_END:     codes.end_code     <= cfg.data;
				CFG_SEGMENT: codes.segment_code <= cfg.data;
				CFG_CHUNK:   codes.chunk_code   <= cfg.data;
				CFG_META:    codes.meta_code    <= cfg.data;
				default: ;
			endcase
		end
	end
endmodule

/* sv/tlvp_parser.sv */
module tlvp_parser
	import tlvp_pkg::*;
#(
	parameter int MAX_COMPONENTS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      codes,
	input  logic      step,
	input  in_item_t  item,
	output logic      ev0_valid,
	output out_item_t ev0,
	output logic      ev1_valid,
	output out_item_t ev1
);
	localparam logic [6:0] MAXC = 7'(MAX_COMPONENTS);

	logic [2:0]  phase_q;
	logic [1:0]  hcnt_q;
	logic [23:0] hdr_q;
	logic [15:0] vrem_q, nrem_q, pos_q, cstart_q, tstart_q, lrem_q;
	logic [6:0]  comps_q;
	logic [31:0] chunk_q;
	logic        chunk_seen_q, chunk_act_q, fin_valid_q, err_q;
	logic [31:0] fin_q;
	logic [15:0] poff_q, plen_q, noff_q, nlen_q, mtype_q;
	logic        pend_q;
	logic [6:0]  pidx_q;
	logic [15:0] poffc_q, plenc_q;

	// next-state copies
	logic [2:0]  phase_d;
	logic [1:0]  hcnt_d;
	logic [23:0] hdr_d;
	logic [15:0] vrem_d, nrem_d, cstart_d, tstart_d, lrem_d;
	logic [6:0]  comps_d;
	logic [31:0] chunk_d;
	logic        chunk_seen_d, chunk_act_d, fin_valid_d, err_d;
	logic [31:0] fin_d;
	logic [15:0] poff_d, plen_d, noff_d, nlen_d, mtype_d;
	logic        pend_d;
	logic [6:0]  pidx_d;
	logic [15:0] poffc_d, plenc_d;

	logic        hdone;
	logic [15:0] htype, hlen;
	logic        cdone, emit_comp;
	logic [16:0] ntot;
	logic        ok;

	assign hdone = (hcnt_q == 2'd3);
	assign htype = hdr_q[23:8];
	assign hlen  = {hdr_q[7:0], item.data_byte};
	assign ntot  = {1'b0, hlen} + 17'd4;

	always_comb begin
		phase_d = phase_q; hcnt_d = hcnt_q; hdr_d = hdr_q;
		vrem_d = vrem_q; nrem_d = nrem_q; cstart_d = cstart_q; tstart_d = tstart_q;
		lrem_d = lrem_q; comps_d = comps_q; chunk_d = chunk_q;
		chunk_seen_d = chunk_seen_q; chunk_act_d = chunk_act_q;
		fin_valid_d = fin_valid_q; err_d = err_q; fin_d = fin_q;
		poff_d = poff_q; plen_d = plen_q; noff_d = noff_q; nlen_d = nlen_q;
		mtype_d = mtype_q; pend_d = pend_q; pidx_d = pidx_q;
		poffc_d = poffc_q; plenc_d = plenc_q;
		cdone = 1'b0;

		if (phase_q != PH_LEAD && lrem_q != 16'd0) lrem_d = lrem_q - 16'd1;

		// header shift for header phases
		if (phase_q == PH_LEAD || phase_q == PH_TOP_HDR || phase_q == PH_NAME_HDR ||
				phase_q == PH_META_HDR) begin
			hdr_d  = {hdr_q[15:0], item.data_byte};
			hcnt_d = hcnt_q + 2'd1;
		end

		unique case (phase_q)
			PH_LEAD: if (hdone) begin
				mtype_d = htype;
				lrem_d  = hlen;
				phase_d = PH_TOP_HDR;
			end
			PH_TOP_HDR: begin
				if (hcnt_q == 2'd0) tstart_d = pos_q;
				if (hdone) begin
					vrem_d = hlen;
					if (htype == codes.name_code) begin
						noff_d = (hcnt_q == 2'd0) ? pos_q : tstart_q;
						nlen_d = ntot[16] ? 16'hFFFF : ntot[15:0];
						nrem_d = hlen;
						if (hlen == 16'd0) phase_d = PH_TOP_HDR;
						else if (hlen < 16'd4) begin err_d = 1'b1; phase_d = PH_DRAIN; end
						else phase_d = PH_NAME_HDR;
					end else if (htype == codes.end_code) begin
						fin_valid_d = 1'b1;
						fin_d = 32'd0;
						phase_d = (hlen == 16'd0) ? PH_TOP_HDR : PH_END_VAL;
					end else begin
						if (htype == codes.payload_code) begin
							poff_d = pos_q + 16'd1;
							plen_d = hlen;
						end
						phase_d = (hlen == 16'd0) ? PH_TOP_HDR : PH_TOP_SKIP;
					end
				end
			end
			PH_TOP_SKIP: begin
				vrem_d = vrem_q - 16'd1;
				if (vrem_d == 16'd0) phase_d = PH_TOP_HDR;
			end
			PH_END_VAL: begin
				fin_d = {fin_q[23:0], item.data_byte};
				vrem_d = vrem_q - 16'd1;
				if (vrem_d == 16'd0) phase_d = PH_TOP_HDR;
			end
			PH_NAME_HDR: begin
				if (hcnt_q == 2'd0) cstart_d = pos_q;
				nrem_d = nrem_q - 16'd1;
				if (hdone) begin
					if (htype == codes.chunk_code || htype == codes.segment_code) begin
						if (hlen > nrem_d) begin
							err_d = 1'b1; phase_d = PH_DRAIN;
						end else begin
							if (htype == codes.chunk_code) begin
								chunk_seen_d = 1'b1; chunk_d = 32'd0; chunk_act_d = 1'b1;
							end
							if (comps_q < MAXC) begin
								pend_d = 1'b1; pidx_d = comps_q; poffc_d = cstart_q;
								plenc_d = hlen + 16'd4; comps_d = comps_q + 7'd1;
							end
							vrem_d = hlen;
							if (hlen == 16'd0) cdone = 1'b1; else phase_d = PH_COMP_VAL;
						end
					end else if (htype == codes.meta_code) begin
						if (nrem_d < 16'd4) begin err_d = 1'b1; phase_d = PH_DRAIN; end
						else phase_d = PH_META_HDR;
					end else if (hlen > nrem_d) begin
						err_d = 1'b1; phase_d = PH_DRAIN;
					end else begin
						vrem_d = hlen;
						if (hlen == 16'd0) cdone = 1'b1; else phase_d = PH_COMP_VAL;
					end
				end
			end
			PH_COMP_VAL: begin
				if (chunk_act_q) chunk_d = {chunk_q[23:0], item.data_byte};
				vrem_d = vrem_q - 16'd1;
				nrem_d = nrem_q - 16'd1;
				if (vrem_d == 16'd0) cdone = 1'b1;
			end
			PH_META_HDR: begin
				nrem_d = nrem_q - 16'd1;
				if (hdone) begin
					if (hlen > nrem_d) begin
						err_d = 1'b1; phase_d = PH_DRAIN;
					end else begin
						vrem_d = hlen; pend_d = 1'b0; chunk_act_d = 1'b0;
						if (hlen == 16'd0) cdone = 1'b1; else phase_d = PH_COMP_VAL;
					end
				end
			end
			default: ;
		endcase

		emit_comp = cdone && pend_d;
		if (cdone) begin
			pend_d = 1'b0; chunk_act_d = 1'b0;
			if (nrem_d == 16'd0) phase_d = PH_TOP_HDR;
			else if (nrem_d < 16'd4) begin err_d = 1'b1; phase_d = PH_DRAIN; end
			else phase_d = PH_NAME_HDR;
		end
	end

	assign ok = !err_d && phase_d == PH_TOP_HDR && hcnt_d == 2'd0 && lrem_d == 16'd0;

	// summary fields are sampled after this byte's updates
	always_comb begin
		ev0.event_kind      = EV_COMPONENT;
		ev0.last_of_run     = !item.last_byte;
		ev0.message_type    = mtype_d;
		ev0.component_index = pidx_d;
		ev0.item_offset     = poffc_d;
		ev0.item_length     = plenc_d;
		ev0.chunk_number    = chunk_d;
		ev0.has_chunk       = chunk_seen_d;
		ev0.final_block     = fin_valid_d ? {1'b0, fin_d} : {33{1'b1}};
		ev0.component_count = comps_d;
		ev0.name_offset     = noff_d;
		ev0.name_length     = nlen_d;
		ev1 = ev0;
		ev1.event_kind      = ok ? EV_ACCEPT : EV_REJECT;
		ev1.last_of_run     = 1'b1;
		ev1.component_index = 7'd0;
		ev1.item_offset     = poff_d;
		ev1.item_length     = plen_d;
	end
	assign ev0_valid = emit_comp;
	assign ev1_valid = item.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD; hcnt_q <= '0; hdr_q <= '0; vrem_q <= '0; nrem_q <= '0;
			pos_q <= '0; cstart_q <= '0; tstart_q <= '0; lrem_q <= '0; comps_q <= '0;
			chunk_q <= '0; chunk_seen_q <= 1'b0; chunk_act_q <= 1'b0;
			fin_valid_q <= 1'b0; err_q <= 1'b0; fin_q <= '0; poff_q <= '0;
			plen_q <= '0; noff_q <= '0; nlen_q <= '0; mtype_q <= '0; pend_q <= 1'b0;
			pidx_q <= '0; poffc_q <= '0; plenc_q <= '0;
		end else if (step) begin
			if (item.last_byte) begin
				phase_q <= PH_LEAD; hcnt_q <= '0; hdr_q <= '0; vrem_q <= '0;
				nrem_q <= '0; pos_q <= '0; cstart_q <= '0; tstart_q <= '0;
				lrem_q <= '0; comps_q <= '0; chunk_q <= '0; chunk_seen_q <= 1'b0;
				chunk_act_q <= 1'b0; fin_valid_q <= 1'b0; err_q <= 1'b0;
				fin_q <= '0; poff_q <= '0; plen_q <= '0; noff_q <= '0;
				nlen_q <= '0; mtype_q <= '0; pend_q <= 1'b0; pidx_q <= '0;
				poffc_q <= '0; plenc_q <= '0;
			end else begin
				phase_q <= phase_d; hcnt_q <= hcnt_d; hdr_q <= hdr_d;
				vrem_q <= vrem_d; nrem_q <= nrem_d; pos_q <= pos_q + 16'd1;
				cstart_q <= cstart_d; tstart_q <= tstart_d; lrem_q <= lrem_d;
				comps_q <= comps_d; chunk_q <= chunk_d; chunk_seen_q <= chunk_seen_d;
				chunk_act_q <= chunk_act_d; fin_valid_q <= fin_valid_d;
				err_q <= err_d; fin_q <= fin_d; poff_q <= poff_d; plen_q <= plen_d;
				noff_q <= noff_d; nlen_q <= nlen_d; mtype_q <= mtype_d;
				pend_q <= pend_d; pidx_q <= pidx_d; poffc_q <= poffc_d;
				plenc_q <= plenc_d;
			end
		end
	end
endmodule

/* sv/tlvp_outq.sv */
module tlvp_outq
	import tlvp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr0,
	input  out_item_t   d0,
	input  logic        wr1,
	input  out_item_t   d1,
	output logic        can_take,
	tlvp_out_if.source  out
);
	// four-entry queue; takes up to two items per cycle
	out_item_t   mem [4];
	logic [1:0]  rd_q, wr_q;
	logic [2:0]  cnt_q;
	logic        pop;
	logic [1:0]  nwr;

	assign pop = out.valid && out.ready;
	assign nwr = {1'b0, wr0} + {1'b0, wr1};
	assign out.valid = (cnt_q != 3'd0);
	assign out.payload = mem[rd_q];
	// room for two more at the end of this cycle
	assign can_take = (cnt_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (wr0) mem[wr_q] <= d0;
		if (wr1) mem[wr0 ? wr_q + 2'd1 : wr_q] <= d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + nwr;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, nwr} - {2'b0, pop};
		end
	end
endmodule

/* tb/tlv_packet_name_parser_core_tb.sv */
module tlv_packet_name_parser_core_tb;
	import tlvp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	class tlv_scoreboard;
		out_item_t   expq[$];
		int          errors;
		logic [15:0] codes[NUM_CFG];
		logic [2:0]  phase;
		int          hcnt;
		logic [31:0] hshift;
		logic [15:0] ctype, vrem, nrem, bpos, cstart, tstart, lrem, msg_type;
		int          comps;
		logic [31:0] chunk_acc, fin_val;
		bit          chunk_seen, chunk_act, fin_valid, err;
		logic [15:0] pay_off, pay_len, nm_off, nm_len;
		bit          pend_v;
		int          pend_idx;
		logic [15:0] pend_off, pend_len;

		function new();
			codes[CFG_NAME] = 16'd0;
			codes[CFG_PAYLOAD] = 16'd1;
			codes[CFG_END] = 16'd25;
			codes[CFG_SEGMENT] = 16'd1;
			codes[CFG_CHUNK] = 16'd16;
			codes[CFG_META] = 16'd17;
			errors = 0;
			clear();
		endfunction

		function void clear();
			phase = PH_LEAD; hcnt = 0; hshift = 0; ctype = 0; vrem = 0; nrem = 0;
			bpos = 0; cstart = 0; tstart = 0; lrem = 0; comps = 0; chunk_acc = 0;
			chunk_seen = 0; chunk_act = 0; fin_valid = 0; fin_val = 0; pay_off = 0;
			pay_len = 0; nm_off = 0; nm_len = 0; err = 0; msg_type = 0; pend_v = 0;
			pend_idx = 0; pend_off = 0; pend_len = 0;
		endfunction

		function void push(logic [1:0] kind, int idx, logic [15:0] off, logic [15:0] len);
			out_item_t r;
			r.event_kind = kind;
			r.last_of_run = 1'b0;
			r.message_type = msg_type;
			r.component_index = idx[6:0];
			r.item_offset = off;
			r.item_length = len;
			r.chunk_number = chunk_acc;
			r.has_chunk = chunk_seen;
			r.final_block = fin_valid ? {1'b0, fin_val} : {33{1'b1}};
			r.component_count = comps[6:0];
			r.name_offset = nm_off;
			r.name_length = nm_len;
			expq.push_back(r);
		endfunction

		function bit hdr_byte(logic [7:0] b);
			hshift = {hshift[23:0], b};
			if (hcnt == 3) begin
				hcnt = 0;
				ctype = hshift[31:16];
				return 1;
			end
			hcnt = hcnt + 1;
			return 0;
		endfunction

		function void bad();
			err = 1;
			phase = PH_DRAIN;
		endfunction

		function void comp_done();
			if (pend_v)
				push(EV_COMPONENT, pend_idx, pend_off, pend_len);
			pend_v = 0;
			chunk_act = 0;
			if (nrem == 0)
				phase = PH_TOP_HDR;
			else if (nrem < 4)
				bad();
			else
				phase = PH_NAME_HDR;
		endfunction

		function void comp_hdr(logic [15:0] t, logic [15:0] l);
			bit is_chunk;
			is_chunk = (t == codes[CFG_CHUNK]);
			if (is_chunk || t == codes[CFG_SEGMENT]) begin
				if (l > nrem) begin
					bad();
					return;
				end
				if (is_chunk) begin
					chunk_seen = 1;
					chunk_acc = 0;
					chunk_act = 1;
				end
				if (comps < 64) begin
					pend_v = 1;
					pend_idx = comps;
					pend_off = cstart;
					pend_len = l + 16'd4;
					comps++;
				end
			end else if (t == codes[CFG_META]) begin
				if (nrem < 4)
					bad();
				else
					phase = PH_META_HDR;
				return;
			end else if (l > nrem) begin
				bad();
				return;
			end
			vrem = l;
			if (l == 0)
				comp_done();
			else
				phase = PH_COMP_VAL;
		endfunction

		function void top_hdr(logic [15:0] t, logic [15:0] l, logic [15:0] pos);
			int total;
			vrem = l;
			if (t == codes[CFG_NAME]) begin
				total = int'(l) + 4;
				nm_off = tstart;
				nm_len = (total > 65535) ? 16'hFFFF : total[15:0];
				nrem = l;
				if (l == 0)
					phase = PH_TOP_HDR;
				else if (l < 4)
					bad();
				else
					phase = PH_NAME_HDR;
				return;
			end
			if (t == codes[CFG_END]) begin
				fin_valid = 1;
				fin_val = 0;
				phase = (l == 0) ? PH_TOP_HDR : PH_END_VAL;
				return;
			end
			if (t == codes[CFG_PAYLOAD]) begin
				pay_off = pos + 16'd1;
				pay_len = l;
			end
			phase = (l == 0) ? PH_TOP_HDR : PH_TOP_SKIP;
		endfunction

		function void note(in_item_t it);
			logic [15:0] pos, l;
			int n0;
			bit ok;
			out_item_t r;
			n0 = expq.size();
			pos = bpos;
			if (phase != PH_LEAD && lrem > 0)
				lrem--;
			case (phase)
				PH_LEAD: begin
					if (hdr_byte(it.data_byte)) begin
						msg_type = ctype;
						lrem = hshift[15:0];
						phase = PH_TOP_HDR;
					end
				end
				PH_TOP_HDR: begin
					if (hcnt == 0)
						tstart = pos;
					if (hdr_byte(it.data_byte))
						top_hdr(ctype, hshift[15:0], pos);
				end
				PH_TOP_SKIP: begin
					vrem--;
					if (vrem == 0)
						phase = PH_TOP_HDR;
				end
				PH_END_VAL: begin
					fin_val = {fin_val[23:0], it.data_byte};
					vrem--;
					if (vrem == 0)
						phase = PH_TOP_HDR;
				end
				PH_NAME_HDR: begin
					if (hcnt == 0)
						cstart = pos;
					nrem--;
					if (hdr_byte(it.data_byte))
						comp_hdr(ctype, hshift[15:0]);
				end
				PH_COMP_VAL: begin
					if (chunk_act)
						chunk_acc = {chunk_acc[23:0], it.data_byte};
					vrem--;
					nrem--;
					if (vrem == 0)
						comp_done();
				end
				PH_META_HDR: begin
					nrem--;
					if (hdr_byte(it.data_byte)) begin
						l = hshift[15:0];
						if (l > nrem) begin
							bad();
						end else begin
							vrem = l;
							pend_v = 0;
							chunk_act = 0;
							if (l == 0)
								comp_done();
							else
								phase = PH_COMP_VAL;
						end
					end
				end
				default: ;
			endcase
			bpos = pos + 16'd1;
			if (it.last_byte) begin
				ok = !err && phase == PH_TOP_HDR && hcnt == 0 && lrem == 0;
				push(ok ? EV_ACCEPT : EV_REJECT, 0, pay_off, pay_len);
				clear();
			end
			if (expq.size() > n0) begin
				r = expq.pop_back();
				r.last_of_run = 1'b1;
				expq.push_back(r);
			end
		endfunction

		function void cmp(string fname, logic [63:0] e, logic [63:0] a);
			if (e !== a) begin
				errors++;
				$display("%0t mismatch %s: expected %0h actual %0h", $realtime, fname, e, a);
			end
		endfunction

		function void check(out_item_t a);
			out_item_t e;
			if (expq.size() == 0) begin
				errors++;
				$display("%0t unexpected result: expected none actual %0h", $realtime, a);
				return;
			end
			e = expq.pop_front();
			cmp("event_kind", 64'(e.event_kind), 64'(a.event_kind));
			cmp("last_of_run", 64'(e.last_of_run), 64'(a.last_of_run));
			cmp("message_type", 64'(e.message_type), 64'(a.message_type));
			cmp("component_index", 64'(e.component_index), 64'(a.component_index));
			cmp("item_offset", 64'(e.item_offset), 64'(a.item_offset));
			cmp("item_length", 64'(e.item_length), 64'(a.item_length));
			cmp("chunk_number", 64'(e.chunk_number), 64'(a.chunk_number));
			cmp("has_chunk", 64'(e.has_chunk), 64'(a.has_chunk));
			cmp("final_block", 64'(e.final_block), 64'(a.final_block));
			cmp("component_count", 64'(e.component_count), 64'(a.component_count));
			cmp("name_offset", 64'(e.name_offset), 64'(a.name_offset));
			cmp("name_length", 64'(e.name_length), 64'(a.name_length));
		endfunction
	endclass

	typedef logic [7:0] byte_q_t[$];

	logic clk;
	logic arst_n;
	tlvp_in_if  in_ch();
	tlvp_out_if out_ch();
	tlvp_cfg_if cfg();

	tlv_packet_name_parser_core uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	tlv_scoreboard sb;
	int tx_idle, rx_idle;
	bit hold_rx;
	int quiet;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk)
		out_ch.ready = !hold_rx && ($urandom_range(99) >= rx_idle);

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check(out_ch.payload);
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg.valid && cfg.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= 5000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_byte(logic [7:0] b, logic l);
		in_item_t it;
		while ($urandom_range(99) < tx_idle) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
		end
		@(negedge clk);
		it.data_byte = b;
		it.last_byte = l;
		in_ch.valid = 1'b1;
		in_ch.payload = it;
		do @(posedge clk); while (!in_ch.ready);
		sb.note(it);
	endtask

	task automatic send_packet(byte_q_t q);
		foreach (q[i])
			send_byte(q[i], i == q.size() - 1);
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	task automatic drain();
		while (sb.expq.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data = val;
		do @(posedge clk); while (!cfg.ready);
		sb.codes[idx] = val;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	function automatic void put_hdr(ref byte_q_t q, input logic [15:0] t, input logic [15:0] l);
		q.push_back(t[15:8]);
		q.push_back(t[7:0]);
		q.push_back(l[15:8]);
		q.push_back(l[7:0]);
	endfunction

	function automatic void put_rand(ref byte_q_t q, input int n);
		repeat (n) q.push_back(8'($urandom_range(255)));
	endfunction

	function automatic byte_q_t make_name(int ncomp);
		byte_q_t c, r;
		int len;
		repeat (ncomp) begin
			case ($urandom_range(3))
				0: begin
					len = $urandom_range(3);
					put_hdr(c, sb.codes[CFG_SEGMENT], 16'(len));
					put_rand(c, len);
				end
				1: begin
					len = $urandom_range(6);
					put_hdr(c, sb.codes[CFG_CHUNK], 16'(len));
					put_rand(c, len);
				end
				2: begin
					len = $urandom_range(3);
					put_hdr(c, sb.codes[CFG_META], 16'($urandom_range(65535)));
					put_hdr(c, 16'($urandom_range(65535)), 16'(len));
					put_rand(c, len);
				end
				default: begin
					len = $urandom_range(2);
					put_hdr(c, 16'($urandom_range(65535)), 16'(len));
					put_rand(c, len);
				end
			endcase
		end
		put_hdr(r, sb.codes[CFG_NAME], 16'(c.size()));
		r = {r, c};
		return r;
	endfunction

	function automatic byte_q_t make_packet(bit long_name);
		byte_q_t body, p;
		int len;
		// more empty segments than can be recorded
		if (long_name) begin
			put_hdr(body, sb.codes[CFG_NAME], 16'(66 * 4));
			repeat (66) put_hdr(body, sb.codes[CFG_SEGMENT], 16'd0);
		end
		repeat ($urandom_range(3)) begin
			case ($urandom_range(3))
				0: body = {body, make_name($urandom_range(4))};
				1: begin
					len = $urandom_range(5);
					put_hdr(body, sb.codes[CFG_END], 16'(len));
					put_rand(body, len);
				end
				2: begin
					len = $urandom_range(4);
					put_hdr(body, sb.codes[CFG_PAYLOAD], 16'(len));
					put_rand(body, len);
				end
				default: begin
					len = $urandom_range(3);
					put_hdr(body, 16'($urandom_range(65535)), 16'(len));
					put_rand(body, len);
				end
			endcase
		end
		len = body.size();
		if ($urandom_range(9) == 0)
			len = $urandom_range(65535);
		put_hdr(p, 16'($urandom_range(65535)), 16'(len));
		p = {p, body};
		// broken sequences and noise
		if (!long_name) begin
			case ($urandom_range(9))
				0: while (p.size() > 1 && $urandom_range(3) != 0) void'(p.pop_back());
				1: p[$urandom_range(p.size() - 1)] = 8'($urandom_range(255));
				2: begin
					p.delete();
					put_rand(p, $urandom_range(1, 8));
				end
				default: ;
			endcase
		end
		return p;
	endfunction

	initial begin
		byte_q_t q;
		logic [15:0] settings[6][NUM_CFG];
		int sent;
		sb = new();
		arst_n = 1'b0;
		hold_rx = 1'b0;
		tx_idle = 0;
		rx_idle = 0;
		quiet = 0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty message, extreme type
		q = '{8'hFF, 8'hFF, 8'h00, 8'h00};
		send_packet(q);
		// too short for the message header
		q = '{8'h00};
		send_packet(q);
		// chunk wider than 32 bits and a meta component, then end-chunk and payload
		q = '{8'h00, 8'h07, 8'h00, 8'h1D,
			8'h00, 8'h00, 8'h00, 8'h11,
			8'h00, 8'h10, 8'h00, 8'h05, 8'h01, 8'h02, 8'h03, 8'h04, 8'hFF,
			8'h00, 8'h11, 8'h00, 8'h00, 8'h00, 8'h09, 8'h00, 8'h00,
			8'h00, 8'h19, 8'h00, 8'h00,
			8'h00, 8'h01, 8'h00, 8'h00};
		send_packet(q);
		// segment longer than its name
		q = '{8'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 8'h04,
			8'h00, 8'h01, 8'h00, 8'h05};
		send_packet(q);
		drain();

		settings[0] = '{16'd0, 16'd1, 16'd25, 16'd1, 16'd16, 16'd17};
		settings[1] = '{16'd0, 16'd1, 16'd25, 16'd1, 16'd16, 16'd17};
		settings[2] = '{16'hFFFF, 16'd0, 16'hFFFE, 16'hFFFF, 16'd0, 16'h8000};
		settings[3] = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
		foreach (settings[4][k])
			settings[4][k] = 16'($urandom_range(7));
		settings[5] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};

		for (int p = 0; p < 6; p++) begin
			for (int k = 0; k < NUM_CFG; k++)
				write_reg(k[2:0], settings[p][k]);
			case (p % 4)
				0: begin tx_idle = 0;  rx_idle = 0;  end
				1: begin tx_idle = 77; rx_idle = 0;  end
				2: begin tx_idle = 0;  rx_idle = 77; end
				default: begin tx_idle = 17; rx_idle = 17; end
			endcase
			if (p == 4) begin
				tx_idle = 0;
				fork
					begin
						hold_rx = 1'b1;
						repeat (300) @(posedge clk);
						hold_rx = 1'b0;
					end
				join_none
			end
			sent = 0;
			while (sent < 20) begin
				q = make_packet(p == 4 && sent == 0);
				send_packet(q);
				sent += q.size();
				// sender waits for every result once
				if (p == 2 && sent > 10 && sent - q.size() <= 10)
					drain();
			end
			drain();
		end
		tx_idle = 0;
		rx_idle = 0;
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expq.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
